>>> rtl/core/hws_pkg.sv
// ----------------------------------------------------------------------------
// hws_pkg
// Shared types and constants of the heartbeat watchdog supervisor.
// ----------------------------------------------------------------------------
package hws_pkg;

  localparam int FIELD_W   = 8;
  localparam int LIMIT_W   = 16;
  localparam int FAIL_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST    = 16'd1000;
  localparam logic [FIELD_W-1:0] CRIT_MASK_RST     = 8'hFF;

  localparam logic REG_FAIL_LIMIT    = 1'b0;
  localparam logic REG_CRITICAL_MASK = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RESTART  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CRITICAL = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0]  restart_mask;
    logic                shutdown;
    logic [FAIL_W-1:0]   failed_channel;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

>>> rtl/core/hws_lane.sv
// ----------------------------------------------------------------------------
// hws_lane
// Per-channel timer: beat/restart clear it, saturating count-up, timeout flag.
// ----------------------------------------------------------------------------
module hws_lane #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  logic                        beat,
  input  logic                        restart,
  input  logic [hws_pkg::LIMIT_W-1:0] fail_limit,
  output logic                        fail
);
  import hws_pkg::*;

  localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] timer_nxt;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]      timer_cmp;
  logic [CMP_W-1:0]      limit_cmp;

  assign timer_inc = (&timer_r) ? timer_r : timer_r + TIMER_BITS'(1);
  assign timer_cmp = CMP_W'(timer_inc);
  assign limit_cmp = CMP_W'(fail_limit);
  assign fail      = !beat && (timer_cmp > limit_cmp);

  always_comb begin
    timer_nxt = timer_r;
    if (tick) begin
      if (beat || restart) begin
        timer_nxt = '0;
      end else begin
        timer_nxt = timer_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else begin
      timer_r <= timer_nxt;
    end
  end

endmodule

>>> rtl/core/hws_merge.sv
// ----------------------------------------------------------------------------
// hws_merge
// Combines lane timeouts: lowest critical failure wins, restarts below it.
// ----------------------------------------------------------------------------
module hws_merge #(
  parameter int CHANNELS = 8
) (
  input  logic [CHANNELS-1:0]        fail,
  input  logic [CHANNELS-1:0]        critical,
  output logic [CHANNELS-1:0]        restart,
  output logic                       crit_hit,
  output logic [hws_pkg::FAIL_W-1:0] failed_channel
);
  import hws_pkg::*;

  logic [CHANNELS-1:0] crit_fail;
  logic [CHANNELS-1:0] crit_low;
  logic [CHANNELS-1:0] below;

  assign crit_fail = fail & critical;
  assign crit_low  = crit_fail & (~crit_fail + CHANNELS'(1));
  assign crit_hit  = |crit_fail;
  assign below     = crit_hit ? (crit_low - CHANNELS'(1)) : '1;
  assign restart   = fail & ~critical & below;

  always_comb begin
    failed_channel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (crit_low[i]) begin
        failed_channel = failed_channel | FAIL_W'(i);
      end
    end
  end

endmodule

>>> rtl/core/hws_outbuf.sv
// ----------------------------------------------------------------------------
// hws_outbuf
// Output register with skid stage; absorbs one result under downstream stall.
// ----------------------------------------------------------------------------
module hws_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hws_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output hws_pkg::res_t out_data
);
  import hws_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  logic skid_valid_r;
  logic skid_valid_nxt;
  res_t out_data_r;
  res_t skid_data_r;
  logic take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = push;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

>>> rtl/core/heartbeat_watchdog_supervisor_top.sv
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor_top
// Multi-channel heartbeat watchdog: one lane per channel plus priority merge.
// ----------------------------------------------------------------------------
// Result: registered in the output stage, or in the skid stage while stalled.
// Throughput: 1 transaction per cycle while in_stall is low; lane timer update
// and merge are combinational, a skid stage absorbs one transaction per stall.
// Reset (rst_n low, synchronous): timers and shutdown cleared, fail limit
// 1000, critical_mask 0xFF, output and skid stages empty.
module heartbeat_watchdog_supervisor_top #(
  parameter int CHANNELS   = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hws_pkg::FIELD_W-1:0]    in_heartbeat_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hws_pkg::FIELD_W-1:0]    out_restart_mask,
  output logic                           out_shutdown,
  output logic [hws_pkg::FAIL_W-1:0]     out_failed_channel,
  output logic [hws_pkg::STATUS_W-1:0]   out_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hws_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hws_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hws_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hws_pkg::*;

  logic [LIMIT_W-1:0]  fail_limit_r;
  logic [FIELD_W-1:0]  critical_mask_r;
  logic                shutdown_r;
  logic                shutdown_nxt;
  logic                cfg_wr;
  logic                reg_sel;
  logic                tick;
  logic                buf_full;
  logic [CHANNELS-1:0] beat;
  logic [CHANNELS-1:0] critical;
  logic [CHANNELS-1:0] fail;
  logic [CHANNELS-1:0] restart;
  logic                crit_hit;
  logic [FAIL_W-1:0]   failed_channel;
  res_t                result;
  res_t                out_data;

  // Configuration
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      REG_FAIL_LIMIT:    prdata = CFG_DATA_W'(fail_limit_r);
      REG_CRITICAL_MASK: prdata = CFG_DATA_W'(critical_mask_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_limit_r    <= FAIL_LIMIT_RST;
      critical_mask_r <= CRIT_MASK_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_FAIL_LIMIT:    fail_limit_r    <= pwdata[LIMIT_W-1:0];
        REG_CRITICAL_MASK: critical_mask_r <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transaction
  assign in_stall = buf_full;
  assign tick     = in_valid && !buf_full;

  // Lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    if (g < FIELD_W) begin : g_mapped
      assign beat[g]     = in_heartbeat_bits[g];
      assign critical[g] = critical_mask_r[g];
    end else begin : g_unmapped
      assign beat[g]     = 1'b0;
      assign critical[g] = 1'b0;
    end

    hws_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tick       (tick),
      .beat       (beat[g]),
      .restart    (restart[g]),
      .fail_limit (fail_limit_r),
      .fail       (fail[g])
    );
  end

  hws_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .fail           (fail),
    .critical       (critical),
    .restart        (restart),
    .crit_hit       (crit_hit),
    .failed_channel (failed_channel)
  );

  // Sticky shutdown
  assign shutdown_nxt = shutdown_r || (tick && crit_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shutdown_r <= 1'b0;
    end else begin
      shutdown_r <= shutdown_nxt;
    end
  end

  // Result assembly
  for (genvar j = 0; j < FIELD_W; j++) begin : g_field
    if (j < CHANNELS) begin : g_used
      assign result.restart_mask[j] = restart[j];
    end else begin : g_unused
      assign result.restart_mask[j] = 1'b0;
    end
  end

  assign result.shutdown       = shutdown_r || crit_hit;
  assign result.failed_channel = failed_channel;
  assign result.status         = crit_hit ? STATUS_CRITICAL :
                                 ((|restart) ? STATUS_RESTART : STATUS_OK);

  hws_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_restart_mask   = out_data.restart_mask;
  assign out_shutdown       = out_data.shutdown;
  assign out_failed_channel = out_data.failed_channel;
  assign out_status         = out_data.status;

endmodule

>>> bench/heartbeat_watchdog_supervisor_top_tb.sv
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor_top_tb
// Self-checking bench for the multi-channel heartbeat watchdog. Drives tick
// transactions through the valid/stall input channel and keeps a cycle-free
// model of every channel timer and the sticky shutdown. Every result
// transaction is checked field by field against the oldest predicted tick.
// Covers register access, restart requests, an all-ones fail limit, critical
// priority, sticky shutdown, random traffic over many register settings and
// a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_supervisor_top_tb;
  import hws_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int TIMER_BITS  = 16;
  localparam int HOLD_CYCLES = 250;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FAIL_LIMIT    = {REG_FAIL_LIMIT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_CRITICAL_MASK = {REG_CRITICAL_MASK, 2'b00};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FIELD_W-1:0]    in_heartbeat_bits = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_W-1:0]    out_restart_mask;
  logic                  out_shutdown;
  logic [FAIL_W-1:0]     out_failed_channel;
  logic [STATUS_W-1:0]   out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // watchdog model state
  logic [TIMER_BITS-1:0] lane_timer [CHANNELS];
  logic                  shutdown_latch = 1'b0;
  logic [LIMIT_W-1:0]    fail_limit_q = FAIL_LIMIT_RST;
  logic [FIELD_W-1:0]    critical_mask_q = CRIT_MASK_RST;
  res_t                  expected_ticks [$];

  int   errors = 0;
  int   ticks_sent = 0;
  int   restarts_expected = 0;
  int   criticals_expected = 0;
  int   settings_applied = 0;

  // traffic shaping
  logic gaps_on = 1'b1;
  int   burst_left = 0;
  int   stall_pct = 25;
  int   run_left = 0;
  logic stall_now = 1'b0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;

  always #5 clk = ~clk;

  heartbeat_watchdog_supervisor_top #(
    .CHANNELS   (CHANNELS),
    .TIMER_BITS (TIMER_BITS)
  ) i_dut (.*);

  function automatic res_t predict_tick(input logic [FIELD_W-1:0] beats);
    logic [FIELD_W-1:0] restart;
    logic               critical_hit;
    logic [FAIL_W-1:0]  failed;
    res_t               r;
    restart      = '0;
    critical_hit = 1'b0;
    failed       = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (beats[ch]) begin
        lane_timer[ch] = '0;
      end else begin
        if (lane_timer[ch] != '1) lane_timer[ch] = lane_timer[ch] + 1'b1;
        if (lane_timer[ch] > fail_limit_q) begin
          if (critical_mask_q[ch]) begin
            if (!critical_hit) begin
              critical_hit = 1'b1;
              failed       = FAIL_W'(ch);
            end
          end else if (!critical_hit) begin
            restart[ch]    = 1'b1;
            lane_timer[ch] = '0;
          end
        end
      end
    end
    if (critical_hit) shutdown_latch = 1'b1;
    r.restart_mask   = restart;
    r.shutdown       = shutdown_latch;
    r.failed_channel = failed;
    r.status         = critical_hit ? STATUS_CRITICAL :
                       (restart != '0) ? STATUS_RESTART : STATUS_OK;
    return r;
  endfunction

  task automatic send_tick(input logic [FIELD_W-1:0] beats);
    int   gap;
    res_t r;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_heartbeat_bits <= beats;
    do @(posedge clk); while (in_stall);
    r = predict_tick(beats);
    expected_ticks.push_back(r);
    ticks_sent++;
    if (r.status == STATUS_CRITICAL) criticals_expected++;
    else if (r.status == STATUS_RESTART) restarts_expected++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [CFG_ADDR_W-1:0] addr);
    logic [CFG_DATA_W-1:0] rd;
    logic [CFG_DATA_W-1:0] want;
    apb_access(1'b0, addr, '0, rd);
    want = (addr == ADDR_FAIL_LIMIT) ? CFG_DATA_W'(fail_limit_q) :
                                       CFG_DATA_W'(critical_mask_q);
    if (rd !== want) begin
      $error("prdata @%0h: expected %0h, got %0h", addr, want, rd);
      errors++;
    end
  endtask

  task automatic set_register(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [LIMIT_W-1:0] value);
    logic [CFG_DATA_W-1:0] unused;
    apb_access(1'b1, addr, CFG_DATA_W'(value), unused);
    if (addr == ADDR_FAIL_LIMIT) fail_limit_q = value;
    else if (addr == ADDR_CRITICAL_MASK) critical_mask_q = value[FIELD_W-1:0];
    settings_applied++;
    check_register(addr);
  endtask

  // output stall pattern plus the long hold on request
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      if (run_left <= 0) begin
        stall_now = ($urandom_range(0, 99) < stall_pct);
        run_left  = $urandom_range(1, 6);
      end
      run_left--;
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $error("result transaction with no tick pending");
        errors++;
      end else begin
        want = expected_ticks.pop_front();
        if (out_restart_mask !== want.restart_mask) begin
          $error("restart_mask: expected %0h, got %0h", want.restart_mask, out_restart_mask);
          errors++;
        end
        if (out_shutdown !== want.shutdown) begin
          $error("shutdown: expected %0d, got %0d", want.shutdown, out_shutdown);
          errors++;
        end
        if (out_failed_channel !== want.failed_channel) begin
          $error("failed_channel: expected %0d, got %0d", want.failed_channel,
                 out_failed_channel);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic test_register_access();
    check_register(ADDR_FAIL_LIMIT);
    check_register(ADDR_CRITICAL_MASK);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    wait_idle();
    set_register(ADDR_FAIL_LIMIT, 16'hFFFF);
    set_register(ADDR_FAIL_LIMIT, 16'h0000);
    set_register(ADDR_CRITICAL_MASK, 16'h0000);
    set_register(ADDR_CRITICAL_MASK, 16'h00FF);
  endtask

  task automatic test_restart_requests();
    set_register(ADDR_FAIL_LIMIT, 16'd2);
    set_register(ADDR_CRITICAL_MASK, 16'h0000);
    repeat (3) send_tick(8'h00);
    repeat (3) send_tick(8'hAA);
    send_tick(8'hFF);
    wait_idle();
    set_register(ADDR_FAIL_LIMIT, 16'd0);
    send_tick(8'h01);
    send_tick(8'h80);
    send_tick(8'hFF);
    wait_idle();
  endtask

  // a limit of all-ones is never exceeded by a counting timer
  task automatic test_max_limit();
    gaps_on   = 1'b0;
    stall_pct = 0;
    set_register(ADDR_FAIL_LIMIT, 16'hFFFF);
    set_register(ADDR_CRITICAL_MASK, 16'h0000);
    repeat (12) send_tick(8'h0F);
    wait_idle();
    set_register(ADDR_FAIL_LIMIT, 16'hFFFE);
    send_tick(8'h0F);
    send_tick(8'hFF);
    wait_idle();
    gaps_on   = 1'b1;
    stall_pct = 25;
  endtask

  task automatic test_critical_priority();
    set_register(ADDR_FAIL_LIMIT, 16'd0);
    set_register(ADDR_CRITICAL_MASK, 16'h0010);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hEF);
    send_tick(8'hEF);
    wait_idle();
    set_register(ADDR_CRITICAL_MASK, 16'h0081);
    send_tick(8'h00);
    send_tick(8'h7F);
    send_tick(8'hFF);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int phases, input logic allow_critical);
    int                 beat_pct;
    logic [LIMIT_W-1:0] limit;
    logic [FIELD_W-1:0] mask;
    logic [FIELD_W-1:0] beats;
    repeat (phases) begin
      wait_idle();
      case ($urandom_range(0, 6))
        0:       limit = '0;
        1:       limit = 16'd1;
        2, 3:    limit = LIMIT_W'($urandom_range(2, 8));
        4:       limit = LIMIT_W'($urandom_range(9, 40));
        5:       limit = 16'hFFFF;
        default: limit = LIMIT_W'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 3))
        0:       mask = 8'h00;
        1:       mask = 8'hFF;
        default: mask = FIELD_W'($urandom_range(0, 255));
      endcase
      if (!allow_critical) mask = 8'h00;
      set_register(ADDR_FAIL_LIMIT, limit);
      set_register(ADDR_CRITICAL_MASK, LIMIT_W'(mask));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stall_pct = $urandom_range(0, 2) * 25;
      beat_pct  = $urandom_range(20, 90);
      repeat (40) begin
        if ($urandom_range(0, 9) == 0) begin
          beats = FIELD_W'($urandom_range(0, 255));
        end else begin
          for (int ch = 0; ch < CHANNELS; ch++)
            beats[ch] = ($urandom_range(0, 99) < beat_pct);
        end
        send_tick(beats);
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stall_pct = 0;
    hold_reqs++;
    repeat (40) send_tick(FIELD_W'($urandom_range(0, 255)));
    wait_idle();
    gaps_on   = 1'b1;
    stall_pct = 25;
  endtask

  initial begin
    foreach (lane_timer[i]) lane_timer[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_restart_requests();
    test_random_traffic(2, 1'b0);
    test_max_limit();
    test_critical_priority();
    test_random_traffic(6, 1'b1);
    test_backpressure();
    wait_idle();
    $display("Ran %0d watchdog ticks over %0d register writes, with a long output hold.",
             ticks_sent, settings_applied);
    $display("Predicted %0d restart ticks and %0d critical failure ticks.",
             restarts_expected, criticals_expected);
    if (errors == 0) begin
      $display("heartbeat_watchdog_supervisor_top verification clean");
    end else begin
      $display("heartbeat_watchdog_supervisor_top verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("heartbeat_watchdog_supervisor_top verification failed");
    $finish;
  end

endmodule
